// ----- rtl/gpc_pkg.sv -----
package gpc_pkg;

    // Point and centre geometry
    localparam int NUM_CENTERS  = 6;
    localparam int TABLE_ROWS   = 6;
    localparam int NUM_COORDS   = 4;

    // Series and scaling constants
    localparam int SERIES_TERMS = 14;
    localparam int K_STAGES     = 15;
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [28:0] EXP_M1_Q30 = 29'd395007542;
    localparam logic [17:0] COST_MAX   = 18'd262143;
    localparam logic [18:0] COST_BASE  = 19'd4096;

    // Pipeline depths
    localparam int DIST_LAT = 3;
    localparam int EXP_LAT  = 3 * SERIES_TERMS + K_STAGES;
    localparam int TOTAL_LAT = DIST_LAT + EXP_LAT + 2;

    // Register indexes of the configuration port
    typedef enum logic [0:0] {
        REG_PEAK_GAIN     = 1'b0,
        REG_INVERSE_WIDTH = 1'b1
    } cfg_idx_t;

    // Centre coordinates, packed as {x3, x2, x1, x0}
    typedef logic [NUM_COORDS-1:0][3:0] center_t;
    localparam center_t CENTER_TAB [TABLE_ROWS] = '{
        '{4'd5, 4'd5, 4'd3, 4'd2},
        '{4'd5, 4'd5, 4'd7, 4'd2},
        '{4'd5, 4'd5, 4'd3, 4'd5},
        '{4'd5, 4'd5, 4'd7, 4'd5},
        '{4'd5, 4'd5, 4'd3, 4'd8},
        '{4'd5, 4'd5, 4'd7, 4'd8}
    };

    // floor((2^32 - 1) / n) for the series divisors n = 1..14
    localparam logic [31:0] RECIP_TAB [SERIES_TERMS] = '{
        32'd4294967295, 32'd2147483647, 32'd1431655765, 32'd1073741823,
        32'd858993459,  32'd715827882,  32'd613566756,  32'd536870911,
        32'd477218588,  32'd429496729,  32'd390451572,  32'd357913941,
        32'd330382099,  32'd306783378
    };

    // One stage of the exponential lane
    typedef struct packed {
        logic [29:0] f;
        logic [3:0]  k;
        logic        zero;
        logic [30:0] term;
        logic [30:0] aux;
        logic [30:0] sum;
    } exp_stage_t;

endpackage

// ----- rtl/gpc_dist.sv -----
module gpc_dist (
    input  logic                  clk,
    input  logic                  en,
    input  logic [3:0][15:0]      coord,
    input  gpc_pkg::center_t      center,
    input  logic [15:0]           inverse_width,
    output logic [43:0]           arg
);

    logic [15:0] diff [gpc_pkg::NUM_COORDS];
    logic [31:0] sq_reg [gpc_pkg::NUM_COORDS];
    logic [33:0] d2_reg;
    logic [49:0] prod;
    logic [43:0] arg_reg;

    // Absolute difference to the centre on each axis
    always_comb
    begin
        for (int i = 0; i < gpc_pkg::NUM_COORDS; i++)
        begin
            if (coord[i] >= {center[i], 12'd0})
                diff[i] = coord[i] - {center[i], 12'd0};
            else
                diff[i] = {center[i], 12'd0} - coord[i];
        end
        prod = 50'(d2_reg) * 50'(inverse_width);
    end

    // Square, sum, then scale by the inverse width
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < gpc_pkg::NUM_COORDS; i++)
                sq_reg[i] <= 32'(diff[i]) * 32'(diff[i]);
            d2_reg  <= 34'(sq_reg[0]) + 34'(sq_reg[1]) + 34'(sq_reg[2]) + 34'(sq_reg[3]);
            arg_reg <= prod[49:6];
        end
    end

    assign arg = arg_reg;

endmodule

// ----- rtl/gpc_exp.sv -----
module gpc_exp (
    input  logic        clk,
    input  logic        en,
    input  logic [43:0] arg,
    output logic [30:0] val,
    output logic        zero
);

    gpc_pkg::exp_stage_t in_st;
    gpc_pkg::exp_stage_t a_src  [gpc_pkg::SERIES_TERMS];
    gpc_pkg::exp_stage_t a_next [gpc_pkg::SERIES_TERMS];
    gpc_pkg::exp_stage_t b_next [gpc_pkg::SERIES_TERMS];
    gpc_pkg::exp_stage_t c_next [gpc_pkg::SERIES_TERMS];
    gpc_pkg::exp_stage_t a_reg  [gpc_pkg::SERIES_TERMS];
    gpc_pkg::exp_stage_t b_reg  [gpc_pkg::SERIES_TERMS];
    gpc_pkg::exp_stage_t c_reg  [gpc_pkg::SERIES_TERMS];
    gpc_pkg::exp_stage_t k_src  [gpc_pkg::K_STAGES];
    gpc_pkg::exp_stage_t k_next [gpc_pkg::K_STAGES];
    gpc_pkg::exp_stage_t k_reg  [gpc_pkg::K_STAGES];
    logic [60:0] tprod [gpc_pkg::SERIES_TERMS];
    logic [62:0] rprod [gpc_pkg::SERIES_TERMS];
    logic [34:0] back  [gpc_pkg::SERIES_TERMS];
    logic [30:0] rem   [gpc_pkg::SERIES_TERMS];
    logic [30:0] quo   [gpc_pkg::SERIES_TERMS];
    logic [59:0] kprod [gpc_pkg::K_STAGES];

    // Split the argument into integer and fraction
    always_comb
    begin
        in_st.f    = arg[29:0];
        in_st.k    = arg[33:30];
        in_st.zero = |arg[43:34];
        in_st.term = gpc_pkg::ONE_Q30;
        in_st.aux  = '0;
        in_st.sum  = gpc_pkg::ONE_Q30;
    end

    // Series term: multiply by f, estimate the quotient, correct it
    always_comb
    begin
        for (int i = 0; i < gpc_pkg::SERIES_TERMS; i++)
        begin
            a_src[i] = (i == 0) ? in_st : c_reg[(i == 0) ? 0 : i - 1];
            tprod[i] = 61'(a_src[i].term) * 61'(a_src[i].f);
            a_next[i]      = a_src[i];
            a_next[i].term = tprod[i][60:30];

            rprod[i] = 63'(a_reg[i].term) * 63'(gpc_pkg::RECIP_TAB[i]);
            b_next[i]     = a_reg[i];
            b_next[i].aux = rprod[i][62:32];

            back[i]  = 35'(b_reg[i].aux) * 35'(i + 1);
            rem[i]   = b_reg[i].term - back[i][30:0];
            quo[i]   = b_reg[i].aux + 31'(rem[i] >= 31'(i + 1));
            c_next[i]      = b_reg[i];
            c_next[i].term = quo[i];
            if (i % 2 == 0)
                c_next[i].sum = b_reg[i].sum - quo[i];
            else
                c_next[i].sum = b_reg[i].sum + quo[i];
        end
        for (int j = 0; j < gpc_pkg::K_STAGES; j++)
        begin
            k_src[j] = (j == 0) ? c_reg[gpc_pkg::SERIES_TERMS-1]
                                : k_reg[(j == 0) ? 0 : j - 1];
            kprod[j] = 60'(k_src[j].sum) * 60'(gpc_pkg::EXP_M1_Q30);
            k_next[j] = k_src[j];
            if (4'(j) < k_src[j].k)
                k_next[j].sum = 31'(kprod[j][59:30]);
        end
    end

    // Advance the series and the integer-part steps
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < gpc_pkg::SERIES_TERMS; i++)
            begin
                a_reg[i] <= a_next[i];
                b_reg[i] <= b_next[i];
                c_reg[i] <= c_next[i];
            end
            for (int j = 0; j < gpc_pkg::K_STAGES; j++)
                k_reg[j] <= k_next[j];
        end
    end

    assign val  = k_reg[gpc_pkg::K_STAGES-1].sum;
    assign zero = k_reg[gpc_pkg::K_STAGES-1].zero;

endmodule

// ----- rtl/gaussian_potential_cost.sv -----
// Gaussian potential cost: one 4-D point in, one cost out.
// Input stream s_*: tdata carries coord_x0..coord_x3, unsigned Q4.12.
// Output stream m_*: tdata carries cost_value, unsigned Q6.12, which is
// 1.0 plus peak_gain*exp(-d2*inverse_width) summed over six centres,
// saturated at the largest code.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr
// (0 peak_gain, 1 inverse_width); write only while the pipeline is empty.
// Throughput: one point per cycle while the receiver takes results. Each
// exponential lane runs a 14-term series (three stages per term) and then
// the 15 integer-part multiply stages.
// Reset clears all valid bits and loads peak_gain 9.0 and inverse_width 1.0.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops in the same cycle; nothing is lost or repeated.
module gaussian_potential_cost (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // coord_x0, coord_x1, coord_x2, coord_x3
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // cost_value, zero padding
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic [15:0] peak_gain_reg;
    logic [15:0] inverse_width_reg;
    logic [gpc_pkg::TOTAL_LAT-1:0] vld_reg;
    logic        en;
    logic [3:0][15:0] coord;
    logic [43:0] arg   [gpc_pkg::NUM_CENTERS];
    logic [30:0] val   [gpc_pkg::NUM_CENTERS];
    logic        zero  [gpc_pkg::NUM_CENTERS];
    logic [15:0] bump_reg [gpc_pkg::NUM_CENTERS];
    logic [46:0] gprod [gpc_pkg::NUM_CENTERS];
    logic [18:0] total;
    logic [17:0] cost_reg;

    // Advance whenever the output slot is free or being taken
    assign en       = !vld_reg[gpc_pkg::TOTAL_LAT-1] || m_tready;
    assign s_tready = en;
    assign coord    = s_tdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_gain_reg     <= 16'd36864;
            inverse_width_reg <= 16'd4096;
        end
        else if (cfg_we)
        begin
            unique case (gpc_pkg::cfg_idx_t'(cfg_addr))
                gpc_pkg::REG_PEAK_GAIN:     peak_gain_reg     <= cfg_wdata;
                gpc_pkg::REG_INVERSE_WIDTH: inverse_width_reg <= cfg_wdata;
                default:                    ;
            endcase
        end
    end

    // Valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[gpc_pkg::TOTAL_LAT-2:0], s_tvalid};
    end

    // One distance and exponential lane per centre
    for (genvar c = 0; c < gpc_pkg::NUM_CENTERS; c++)
    begin : g_lane
        gpc_dist u_dist (
            .clk           (clk),
            .en            (en),
            .coord         (coord),
            .center        (gpc_pkg::CENTER_TAB[c]),
            .inverse_width (inverse_width_reg),
            .arg           (arg[c])
        );

        gpc_exp u_exp (
            .clk  (clk),
            .en   (en),
            .arg  (arg[c]),
            .val  (val[c]),
            .zero (zero[c])
        );
    end

    // Scale by the peak gain, then sum and saturate
    always_comb
    begin
        total = gpc_pkg::COST_BASE;
        for (int c = 0; c < gpc_pkg::NUM_CENTERS; c++)
        begin
            gprod[c] = 47'(peak_gain_reg) * 47'(val[c]);
            total    = total + 19'(bump_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < gpc_pkg::NUM_CENTERS; c++)
                bump_reg[c] <= zero[c] ? 16'd0 : gprod[c][45:30];
            cost_reg <= (total > 19'(gpc_pkg::COST_MAX)) ? gpc_pkg::COST_MAX : total[17:0];
        end
    end

    assign m_tvalid = vld_reg[gpc_pkg::TOTAL_LAT-1];
    assign m_tdata  = {6'd0, cost_reg};

endmodule

// ----- rtl/gpc_checker.sv -----
module gpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Refuse input while a result is stalled
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken during output stall");

    // Keep the padding clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:18] == 6'd0)
        else $error("padding bits set");

    // Never fall below the base cost of 1.0
    a_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[17:0] >= 18'd4096)
        else $error("cost below base");

endmodule

bind gaussian_potential_cost gpc_checker u_gpc_checker (.*);
